// ===== design/stpr_pkg.sv =====
// Shared types and constants of the stepper ramp generator.
`default_nettype none
package stpr_pkg;

	// Item operation codes
	localparam logic OP_MOVE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Motion phases
	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_ACCEL = 3'd1;
	localparam logic [2:0] PH_RUN   = 3'd2;
	localparam logic [2:0] PH_DECEL = 3'd3;
	localparam logic [2:0] PH_STOP  = 3'd4;

	// Register indexes on the APB port
	localparam logic [1:0] REG_ACCEL = 2'd0;
	localparam logic [1:0] REG_DECEL = 2'd1;
	localparam logic [1:0] REG_SPEED = 2'd2;
	localparam logic [1:0] REG_FREQ  = 2'd3;

	// Field widths
	localparam int RATE_W   = 16;
	localparam int FREQ_W   = 28;
	localparam int MOVE_W   = 16;
	localparam int PERIOD_W = 32;
	localparam int CNT_W    = 17;
	localparam int REST_W   = 20;

	// Serial divider geometry
	localparam int DIV_DVD_W = 48;
	localparam int DIV_DVS_W = 18;
	localparam int DIV_CNT_W = 6;

	// Square root unit: 625 * a stays below 2^26
	localparam int SQRT_W = 26;
	localparam int SQRT_RES_W = 14;
	localparam logic [SQRT_W-1:0] SQRT_TOP = 26'h1000000;
	localparam int SQRT_K = 625;

	localparam int FREQ_K = 24;
	localparam int START_PERIOD = 3;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage
`default_nettype wire

// ===== design/stpr_if.sv =====
// Handshake channels of the stepper ramp generator: move/tick items and results.
`default_nettype none
interface stpr_item_if;
	logic valid;
	logic ready;
	logic operation;
	logic signed [stpr_pkg::MOVE_W-1:0] move_steps;

	modport source(output valid, operation, move_steps, input ready);
	modport sink(input valid, operation, move_steps, output ready);
endinterface

interface stpr_res_if;
	logic valid;
	logic ready;
	logic [stpr_pkg::PERIOD_W-1:0] timer_period;
	logic timer_running;
	logic step_pulse;
	logic direction;
	logic [2:0] phase;
	logic move_done;

	modport source(output valid, timer_period, timer_running, step_pulse, direction, phase,
		move_done, input ready);
	modport sink(input valid, timer_period, timer_running, step_pulse, direction, phase,
		move_done, output ready);
endinterface
`default_nettype wire

// ===== design/stpr_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module stpr_div import stpr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_DVD_W-1:0] dividend,
	input  logic [DIV_DVS_W-1:0] divisor,
	output logic [DIV_DVD_W-1:0] quotient,
	output logic [DIV_DVS_W-1:0] remainder,
	output div_stat_t            stat
);

	logic [DIV_DVS_W-1:0] rem_q;
	logic [DIV_DVD_W-1:0] quo_q;
	logic [DIV_DVS_W-1:0] dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_DVS_W:0]   trial;
	logic [DIV_DVS_W:0]   diff;
	logic                 ge;

	// Shift in the next dividend bit and try the subtract
	always_comb begin
		trial = {rem_q, quo_q[DIV_DVD_W-1]};
		diff  = trial - {1'b0, dvs_q};
		ge    = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			quo_q  <= '0;
			dvs_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= '0;
				quo_q  <= dividend;
				dvs_q  <= divisor;
				cnt_q  <= DIV_CNT_W'(DIV_DVD_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= ge ? diff[DIV_DVS_W-1:0] : trial[DIV_DVS_W-1:0];
				quo_q <= {quo_q[DIV_DVD_W-2:0], ge};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule
`default_nettype wire

// ===== design/stepper_trapezoid_ramp.sv =====
// Stepper speed ramp generator: a move item plans a trapezoidal profile and each
// timer tick item steps the accelerate, run, decelerate and stop phases, returning
// the next timer period. One result per item. All divisions share one serial
// divider, and a move also takes a rounded square root. One item is worked on at
// a time; the result register lets the next item enter while a result waits.
`default_nettype none
module stepper_trapezoid_ramp import stpr_pkg::*; #(
	parameter int DELAY_WIDTH = 32,
	parameter int STEP_WIDTH  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	stpr_item_if.sink   item_in,
	stpr_res_if.source  result_out,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int DW = DELAY_WIDTH;
	localparam int SW = STEP_WIDTH;

	// Sequencer codes
	localparam logic [3:0] SQ_IDLE   = 4'd0;
	localparam logic [3:0] SQ_SQRT   = 4'd1;
	localparam logic [3:0] SQ_CRUISE = 4'd2;
	localparam logic [3:0] SQ_FIRST  = 4'd3;
	localparam logic [3:0] SQ_SMAX   = 4'd4;
	localparam logic [3:0] SQ_ALIM   = 4'd5;
	localparam logic [3:0] SQ_DVAL   = 4'd6;
	localparam logic [3:0] SQ_TICK   = 4'd7;
	localparam logic [3:0] SQ_OUT    = 4'd8;

	// Configuration
	logic [RATE_W-1:0] accel_q, decel_q, speed_q;
	logic [FREQ_W-1:0] freq_q;
	logic [RATE_W-1:0] a_eff, d_eff, v_eff;

	// Ramp state
	logic [3:0]              seq_q;
	logic [2:0]              phase_q;
	logic [DW-1:0]           delay_q, cruise_q, plateau_q;
	logic [SW-1:0]           steps_q, steps_inc;
	logic [CNT_W-1:0]        rcnt_q, dpoint_q, dlen_q, mag_q, n_next;
	logic signed [REST_W-1:0] rest_q, r_s;
	logic                    dir_q;

	// Move planning
	logic [SQRT_W-1:0]     sx_q, sr_q, sb_q, s_sum;
	logic                  s_take;
	logic [SQRT_RES_W-1:0] sq_q;
	logic [31:0]           smax_q;
	logic [31:0]           freq24;

	// Divider hookup
	logic                 div_go_q;
	logic [DIV_DVD_W-1:0] dvd_q, quo;
	logic [DIV_DVS_W-1:0] dvs_q, rem;
	div_stat_t            dstat;
	logic                 neg_dvd_q, neg_quo_q;

	// Tick arithmetic
	logic signed [18:0] dvs19;
	logic [DIV_DVS_W-1:0] dvs_mag;
	logic [33:0] cd2;
	logic signed [34:0] dvd35;
	logic [33:0] dvd_mag;
	logic [33:0] nd_w;
	logic [DW-1:0] nd;

	// Move input
	logic signed [CNT_W-1:0] mv_ext;
	logic [CNT_W-1:0]        mv_mag;

	// Result holding
	logic [PERIOD_W-1:0] period_q, o_period_q;
	logic pulse_q, done_q;
	logic ov_q, o_run_q, o_pulse_q, o_dir_q, o_done_q;
	logic [2:0] o_phase_q;
	logic in_acc;

	stpr_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_go_q),
		.dividend  (dvd_q),
		.divisor   (dvs_q),
		.quotient  (quo),
		.remainder (rem),
		.stat      (dstat)
	);

	// Zero rates count as one
	always_comb begin
		a_eff = (accel_q == '0) ? RATE_W'(1) : accel_q;
		d_eff = (decel_q == '0) ? RATE_W'(1) : decel_q;
		v_eff = (speed_q == '0) ? RATE_W'(1) : speed_q;
	end

	always_comb begin
		item_in.ready = (seq_q == SQ_IDLE);
		in_acc        = item_in.valid && item_in.ready;
		mv_ext        = {item_in.move_steps[MOVE_W-1], item_in.move_steps};
		mv_mag        = mv_ext[CNT_W-1] ? CNT_W'(-mv_ext) : mv_ext;
		steps_inc     = steps_q + SW'(1);
		n_next        = rcnt_q + CNT_W'(1);
		freq24        = 32'(32'(freq_q) * 32'(FREQ_K));

		// Divisor 4n+1 and dividend 2d+rest, split into sign and magnitude
		dvs19   = {n_next, 2'b01};
		dvs_mag = dvs19[18] ? DIV_DVS_W'(-dvs19) : dvs19[DIV_DVS_W-1:0];
		cd2     = 34'(delay_q) << 1;
		dvd35   = $signed({1'b0, cd2}) + 35'(rest_q);
		dvd_mag = dvd35[34] ? 34'(-dvd35) : dvd35[33:0];

		// Apply the truncated signed quotient and remainder
		nd_w = neg_quo_q ? 34'(delay_q) + quo[33:0] : 34'(delay_q) - quo[33:0];
		nd   = nd_w[DW-1:0];
		r_s  = neg_dvd_q ? -$signed(REST_W'(rem)) : $signed(REST_W'(rem));

		// One square root step
		s_sum  = sr_q + sb_q;
		s_take = s_sum <= sx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_q    <= RATE_W'(100);
			decel_q    <= RATE_W'(100);
			speed_q    <= RATE_W'(1000);
			freq_q     <= FREQ_W'(1000000);
			seq_q      <= SQ_IDLE;
			phase_q    <= PH_IDLE;
			delay_q    <= '0;
			cruise_q   <= '0;
			plateau_q  <= '0;
			steps_q    <= '0;
			rcnt_q     <= '0;
			dpoint_q   <= '0;
			dlen_q     <= '0;
			mag_q      <= '0;
			rest_q     <= '0;
			dir_q      <= 1'b0;
			sx_q       <= '0;
			sr_q       <= '0;
			sb_q       <= '0;
			sq_q       <= '0;
			smax_q     <= '0;
			div_go_q   <= 1'b0;
			dvd_q      <= '0;
			dvs_q      <= '0;
			neg_dvd_q  <= 1'b0;
			neg_quo_q  <= 1'b0;
			period_q   <= '0;
			pulse_q    <= 1'b0;
			done_q     <= 1'b0;
			ov_q       <= 1'b0;
			o_period_q <= '0;
			o_run_q    <= 1'b0;
			o_pulse_q  <= 1'b0;
			o_dir_q    <= 1'b0;
			o_phase_q  <= PH_IDLE;
			o_done_q   <= 1'b0;
		end else begin
			div_go_q <= 1'b0;

			// Register writes
			if (psel && penable && pwrite) begin
				unique case (paddr[3:2])
					REG_ACCEL: accel_q <= pwdata[RATE_W-1:0];
					REG_DECEL: decel_q <= pwdata[RATE_W-1:0];
					REG_SPEED: speed_q <= pwdata[RATE_W-1:0];
					REG_FREQ:  freq_q  <= pwdata[FREQ_W-1:0];
					default: ;
				endcase
			end

			// Drop the result once taken
			if (ov_q && result_out.ready) begin
				ov_q <= 1'b0;
			end

			unique case (seq_q)
				SQ_IDLE: begin
					if (in_acc) begin
						if (item_in.operation == OP_MOVE) begin
							dir_q    <= item_in.move_steps[MOVE_W-1];
							mag_q    <= mv_mag;
							sx_q     <= SQRT_W'(SQRT_W'(a_eff) * SQRT_W'(SQRT_K));
							sr_q     <= '0;
							sb_q     <= SQRT_TOP;
							phase_q  <= PH_ACCEL;
							rcnt_q   <= '0;
							period_q <= PERIOD_W'(START_PERIOD);
							pulse_q  <= 1'b0;
							done_q   <= 1'b0;
							seq_q    <= SQ_SQRT;
						end else begin
							period_q <= PERIOD_W'(delay_q);
							pulse_q  <= (phase_q == PH_ACCEL) || (phase_q == PH_RUN) ||
								(phase_q == PH_DECEL);
							done_q   <= (phase_q == PH_STOP);
							unique case (phase_q)
								PH_STOP: begin
									steps_q <= '0;
									rest_q  <= '0;
									phase_q <= PH_IDLE;
									seq_q   <= SQ_OUT;
								end
								PH_ACCEL, PH_DECEL: begin
									steps_q   <= steps_inc;
									rcnt_q    <= n_next;
									dvd_q     <= DIV_DVD_W'(dvd_mag);
									dvs_q     <= dvs_mag;
									div_go_q  <= 1'b1;
									neg_dvd_q <= dvd35[34];
									neg_quo_q <= dvd35[34] ^ dvs19[18];
									seq_q     <= SQ_TICK;
								end
								PH_RUN: begin
									steps_q <= steps_inc;
									seq_q   <= SQ_OUT;
									if (CNT_W'(steps_inc) >= dpoint_q) begin
										rcnt_q  <= dlen_q;
										delay_q <= plateau_q;
										phase_q <= PH_DECEL;
									end else begin
										delay_q <= cruise_q;
									end
								end
								default: seq_q <= SQ_OUT;
							endcase
						end
					end
				end

				// Rounded square root of 625 * acceleration, two bits a cycle
				SQ_SQRT: begin
					if (sb_q == '0) begin
						sq_q     <= (sr_q < sx_q) ? SQRT_RES_W'(sr_q + SQRT_W'(1)) :
							SQRT_RES_W'(sr_q);
						dvd_q    <= DIV_DVD_W'(freq_q);
						dvs_q    <= DIV_DVS_W'(v_eff);
						div_go_q <= 1'b1;
						seq_q    <= SQ_CRUISE;
					end else begin
						if (s_take) begin
							sx_q <= sx_q - s_sum;
						end
						sr_q <= (sr_q >> 1) + (s_take ? sb_q : '0);
						sb_q <= sb_q >> 2;
					end
				end

				SQ_CRUISE: begin
					if (dstat.done) begin
						cruise_q <= quo[DW-1:0];
						dvd_q    <= DIV_DVD_W'(freq24);
						dvs_q    <= DIV_DVS_W'(sq_q);
						div_go_q <= 1'b1;
						seq_q    <= SQ_FIRST;
					end
				end

				SQ_FIRST: begin
					if (dstat.done) begin
						delay_q  <= quo[DW-1:0];
						dvd_q    <= DIV_DVD_W'(32'(v_eff) * 32'(v_eff));
						dvs_q    <= DIV_DVS_W'({a_eff, 1'b0});
						div_go_q <= 1'b1;
						seq_q    <= SQ_SMAX;
					end
				end

				SQ_SMAX: begin
					if (dstat.done) begin
						smax_q   <= quo[31:0];
						dvd_q    <= DIV_DVD_W'(32'(mag_q) * 32'(d_eff));
						dvs_q    <= DIV_DVS_W'(CNT_W'(a_eff) + CNT_W'(d_eff));
						div_go_q <= 1'b1;
						seq_q    <= SQ_ALIM;
					end
				end

				// Deceleration set by the move length or by the top speed
				SQ_ALIM: begin
					if (dstat.done) begin
						if (32'(quo[CNT_W-1:0]) <= smax_q) begin
							dlen_q   <= quo[CNT_W-1:0] - mag_q;
							dpoint_q <= quo[CNT_W-1:0];
							seq_q    <= SQ_OUT;
						end else begin
							dvd_q    <= DIV_DVD_W'(smax_q) * DIV_DVD_W'(a_eff);
							dvs_q    <= DIV_DVS_W'(d_eff);
							div_go_q <= 1'b1;
							seq_q    <= SQ_DVAL;
						end
					end
				end

				SQ_DVAL: begin
					if (dstat.done) begin
						dlen_q   <= CNT_W'(0) - quo[CNT_W-1:0];
						dpoint_q <= mag_q - quo[CNT_W-1:0];
						seq_q    <= SQ_OUT;
					end
				end

				// Finish the delay recurrence and advance the phase
				SQ_TICK: begin
					if (dstat.done) begin
						delay_q <= nd;
						rest_q  <= r_s;
						seq_q   <= SQ_OUT;
						if (phase_q == PH_ACCEL) begin
							if (CNT_W'(steps_q) >= dpoint_q) begin
								rcnt_q  <= dlen_q;
								phase_q <= PH_DECEL;
							end else if (nd <= cruise_q) begin
								plateau_q <= nd;
								delay_q   <= cruise_q;
								rest_q    <= '0;
								phase_q   <= PH_RUN;
							end
						end else if (!rcnt_q[CNT_W-1]) begin
							phase_q <= PH_STOP;
						end
					end
				end

				// Hand the result to the output register
				SQ_OUT: begin
					if (!ov_q || result_out.ready) begin
						ov_q       <= 1'b1;
						o_period_q <= period_q;
						o_run_q    <= (phase_q != PH_IDLE);
						o_pulse_q  <= pulse_q;
						o_dir_q    <= dir_q;
						o_phase_q  <= phase_q;
						o_done_q   <= done_q;
						seq_q      <= SQ_IDLE;
					end
				end

				default: seq_q <= SQ_IDLE;
			endcase
		end
	end

	// Register reads
	always_comb begin
		unique case (paddr[3:2])
			REG_ACCEL: prdata = 32'(accel_q);
			REG_DECEL: prdata = 32'(decel_q);
			REG_SPEED: prdata = 32'(speed_q);
			REG_FREQ:  prdata = 32'(freq_q);
			default:   prdata = '0;
		endcase
	end

	assign pready                   = 1'b1;
	assign result_out.valid         = ov_q;
	assign result_out.timer_period  = o_period_q;
	assign result_out.timer_running = o_run_q;
	assign result_out.step_pulse    = o_pulse_q;
	assign result_out.direction     = o_dir_q;
	assign result_out.phase         = o_phase_q;
	assign result_out.move_done     = o_done_q;

	// The divider is never restarted mid-division
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_go_q |-> !dstat.busy)
		else $error("divider started while busy");

	// A new item only enters with the divider at rest
	a_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		(seq_q == SQ_IDLE) |-> (!dstat.busy && !div_go_q))
		else $error("input ready while divider active");

	// A finished move reports idle and no step
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && o_done_q) |-> (o_phase_q == PH_IDLE && !o_pulse_q && !o_run_q))
		else $error("move done with motor still running");

endmodule
`default_nettype wire

// ===== tb/stepper_trapezoid_ramp_test.sv =====
// Self-checking testbench of the stepper speed ramp generator with its own profile predictor.
`default_nettype none
module stepper_trapezoid_ramp_test;
	timeunit 1ns;
	timeprecision 1ps;
	import stpr_pkg::*;

	typedef struct {
		logic [2:0]  ph;
		logic [31:0] cur_delay;
		logic [15:0] taken;
		logic [16:0] ramp_n;
		logic [31:0] rest;
		logic [16:0] decel_at;
		logic [16:0] decel_len;
		logic [31:0] cruise;
		logic [31:0] plateau;
		logic [31:0] first;
		logic        dir;
	} motion_t;

	typedef struct packed {
		logic [31:0] period;
		logic        running;
		logic        pulse;
		logic        dir;
		logic [2:0]  ph;
		logic        done;
	} timer_res_t;

	typedef struct packed {
		logic        op;
		logic [15:0] steps;
	} motor_cmd_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	stpr_item_if cmd_bus();
	stpr_res_if timer_bus();

	stepper_trapezoid_ramp u_top (
		.clk(clk), .arst_n(arst_n),
		.item_in(cmd_bus), .result_out(timer_bus),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Ramp settings shared by the planner and the checker; changed only when idle
	logic [15:0] accel_rate = 16'd100;
	logic [15:0] decel_rate = 16'd100;
	logic [15:0] speed_max = 16'd1000;
	logic [27:0] tick_hz = 28'd1000000;

	motor_cmd_t cmd_q[$];
	timer_res_t timer_exp_q[$];
	motion_t plan_st;
	motion_t chk_st;
	int mismatches = 0;
	int burst_left = 0;
	int gap_left = 0;
	int stall_mode = 0;
	int mode_cycles = 0;
	logic [15:0] stall_pat = 16'hA5C3;

	function automatic longint unsigned rounded_sqrt(input longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'h40000000;
		while (b != 0) begin
			if (r + b <= x) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return (r < x) ? r + 1 : r;
	endfunction

	// Advance the delay recurrence by one step, carrying the remainder
	function automatic logic [31:0] next_delay(inout motion_t s);
		longint n, dvs, dvd, q, r;
		logic [63:0] nd;
		s.ramp_n = s.ramp_n + 17'd1;
		n = longint'($signed(s.ramp_n));
		dvs = 4 * n + 1;
		dvd = 2 * longint'(s.cur_delay) + longint'($signed(s.rest));
		q = dvd / dvs;
		r = dvd % dvs;
		s.rest = r[31:0];
		nd = longint'(s.cur_delay) - q;
		return nd[31:0];
	endfunction

	function automatic timer_res_t ramp_predict(inout motion_t s, input motor_cmd_t c);
		timer_res_t o;
		longint a, d, v, sv, mag, smax, alim, dval, sum;
		longint unsigned fq;
		logic [31:0] nd;
		o = '0;
		if (c.op == OP_MOVE) begin
			a = (accel_rate == 0) ? 1 : longint'(accel_rate);
			d = (decel_rate == 0) ? 1 : longint'(decel_rate);
			v = (speed_max == 0) ? 1 : longint'(speed_max);
			sv = longint'($signed(c.steps));
			mag = (sv < 0) ? -sv : sv;
			s.dir = (sv < 0);
			s.cruise = 32'(longint'(tick_hz) / v);
			fq = (longint'(tick_hz) * 24) & 64'hFFFF_FFFF;
			s.first = 32'(fq / rounded_sqrt(625 * a));
			s.cur_delay = s.first;
			smax = (v * v) / (2 * a);
			alim = (mag * d) / (a + d);
			if (alim <= smax)
				dval = alim - mag;
			else
				dval = (-smax * a) / d;
			sum = mag + dval;
			s.decel_len = dval[16:0];
			s.decel_at = sum[16:0];
			s.ph = PH_ACCEL;
			s.ramp_n = '0;
			o.period = 32'(START_PERIOD);
		end else begin
			o.period = s.cur_delay;
			nd = s.cur_delay;
			case (s.ph)
				PH_STOP: begin
					s.taken = '0;
					s.rest = '0;
					s.ph = PH_IDLE;
					o.done = 1'b1;
				end
				PH_ACCEL: begin
					o.pulse = 1'b1;
					s.taken = s.taken + 16'd1;
					nd = next_delay(s);
					if ({1'b0, s.taken} >= s.decel_at) begin
						s.ramp_n = s.decel_len;
						s.ph = PH_DECEL;
					end else if (nd <= s.cruise) begin
						s.plateau = nd;
						nd = s.cruise;
						s.rest = '0;
						s.ph = PH_RUN;
					end
				end
				PH_RUN: begin
					o.pulse = 1'b1;
					s.taken = s.taken + 16'd1;
					nd = s.cruise;
					if ({1'b0, s.taken} >= s.decel_at) begin
						s.ramp_n = s.decel_len;
						nd = s.plateau;
						s.ph = PH_DECEL;
					end
				end
				PH_DECEL: begin
					o.pulse = 1'b1;
					s.taken = s.taken + 16'd1;
					nd = next_delay(s);
					if ($signed(s.ramp_n) >= 0)
						s.ph = PH_STOP;
				end
				default: ;
			endcase
			s.cur_delay = nd;
		end
		o.running = (s.ph != PH_IDLE);
		o.dir = s.dir;
		o.ph = s.ph;
		return o;
	endfunction

	function automatic motion_t motion_reset();
		motion_t s;
		s.ph = PH_IDLE;
		s.cur_delay = '0;
		s.taken = '0;
		s.ramp_n = '0;
		s.rest = '0;
		s.decel_at = '0;
		s.decel_len = '0;
		s.cruise = '0;
		s.plateau = '0;
		s.first = '0;
		s.dir = 1'b0;
		return s;
	endfunction

	// Queue one command and track its effect on the planning copy
	task automatic queue_cmd(input logic op, input logic [15:0] steps);
		motor_cmd_t c;
		c.op = op;
		c.steps = steps;
		void'(ramp_predict(plan_st, c));
		cmd_q.push_back(c);
	endtask

	// Tick until the planned move returns to idle, or give up after a cap
	task automatic tick_to_idle(input int cap);
		int k;
		k = 0;
		while (plan_st.ph != PH_IDLE && k < cap) begin
			queue_cmd(OP_TICK, 16'h0);
			k++;
		end
	endtask

	task automatic drain_and_settle();
		wait (cmd_q.size() == 0 && timer_exp_q.size() == 0);
		repeat (300) @(posedge clk);
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_ACCEL: accel_rate = val[15:0];
			REG_DECEL: decel_rate = val[15:0];
			REG_SPEED: speed_max = val[15:0];
			default: tick_hz = val[27:0];
		endcase
	endtask

	task automatic load_profile(input logic [15:0] a, input logic [15:0] d,
			input logic [15:0] v, input logic [27:0] f);
		drain_and_settle();
		reg_write(REG_ACCEL, {16'h0, a});
		reg_write(REG_DECEL, {16'h0, d});
		reg_write(REG_SPEED, {16'h0, v});
		reg_write(REG_FREQ, {4'h0, f});
	endtask

	// Mix of complete short moves, interrupted moves and idle ticks
	task automatic random_moves(input int count);
		int start, sel, mag, k;
		logic [15:0] st;
		start = cmd_q.size();
		k = 0;
		while (k < count) begin
			sel = $urandom_range(0, 9);
			if (sel == 7) begin
				queue_cmd(OP_MOVE, 16'($urandom));
				repeat ($urandom_range(0, 8)) queue_cmd(OP_TICK, 16'($urandom));
			end else if (sel == 8) begin
				repeat ($urandom_range(1, 3)) queue_cmd(OP_TICK, 16'($urandom));
			end else begin
				mag = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 200) :
					$urandom_range(0, 40);
				st = $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
				queue_cmd(OP_MOVE, st);
				if (sel == 9)
					repeat ($urandom_range(1, 6)) queue_cmd(OP_TICK, 16'h0);
				else
					tick_to_idle(400);
			end
			k = cmd_q.size() - start;
		end
		tick_to_idle(400);
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#(30_000_000);
		$display("tb: failure");
		$finish;
	end

	// Drive commands in bursts; hold a pending transaction until accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_bus.valid <= 1'b0;
			cmd_bus.operation <= OP_MOVE;
			cmd_bus.move_steps <= '0;
		end else if (!(cmd_bus.valid && !cmd_bus.ready)) begin
			if (cmd_bus.valid && cmd_bus.ready) begin
				timer_exp_q.push_back(ramp_predict(chk_st, cmd_q[0]));
				cmd_q.pop_front();
			end
			if (gap_left > 0) begin
				gap_left--;
				cmd_bus.valid <= 1'b0;
			end else if (cmd_q.size() > 0) begin
				cmd_bus.valid <= 1'b1;
				cmd_bus.operation <= cmd_q[0].op;
				cmd_bus.move_steps <= cmd_q[0].steps;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 12);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 20);
				end
			end else begin
				cmd_bus.valid <= 1'b0;
			end
		end
	end

	// Stall the result side: always ready, a rotating pattern, or coin flips
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_bus.ready <= 1'b0;
		end else begin
			if (mode_cycles == 0) begin
				stall_mode = $urandom_range(0, 2);
				mode_cycles = $urandom_range(50, 400);
			end
			mode_cycles--;
			stall_pat = {stall_pat[14:0], stall_pat[15]};
			case (stall_mode)
				0: timer_bus.ready <= 1'b1;
				1: timer_bus.ready <= stall_pat[0];
				default: timer_bus.ready <= 1'($urandom_range(0, 1));
			endcase
		end
	end

	// Compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		timer_res_t want;
		timer_res_t got;
		if (arst_n && timer_bus.valid && timer_bus.ready) begin
			got.period = timer_bus.timer_period;
			got.running = timer_bus.timer_running;
			got.pulse = timer_bus.step_pulse;
			got.dir = timer_bus.direction;
			got.ph = timer_bus.phase;
			got.done = timer_bus.move_done;
			if (timer_exp_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: period %0d phase %0d", got.period, got.ph);
			end else begin
				want = timer_exp_q.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: exp period %0d run %b step %b dir %b phase %0d",
							" done %b / got period %0d run %b step %b dir %b phase %0d",
							" done %b"},
							want.period, want.running, want.pulse, want.dir, want.ph, want.done,
							got.period, got.running, got.pulse, got.dir, got.ph, got.done);
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		plan_st = motion_reset();
		chk_st = motion_reset();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: idle ticks, zero move, extreme counts, move during move
		queue_cmd(OP_TICK, 16'hFFFF);
		queue_cmd(OP_MOVE, 16'h0000);
		tick_to_idle(50);
		queue_cmd(OP_TICK, 16'h0);
		queue_cmd(OP_MOVE, 16'sd5);
		tick_to_idle(50);
		queue_cmd(OP_MOVE, 16'h8000);
		queue_cmd(OP_TICK, 16'h0);
		queue_cmd(OP_TICK, 16'h0);
		queue_cmd(OP_MOVE, 16'h7FFF);
		queue_cmd(OP_TICK, 16'h0);
		queue_cmd(OP_MOVE, -16'sd3);
		tick_to_idle(50);
		random_moves(200);

		// Fast acceleration with a low top speed to reach the cruise phase
		load_profile(16'd40000, 16'd20000, 16'd300, 28'd1000000);
		queue_cmd(OP_MOVE, 16'sd20);
		tick_to_idle(100);
		random_moves(220);

		load_profile(16'd1, 16'd1, 16'd1, 28'd1);
		random_moves(120);

		load_profile(16'hFFFF, 16'hFFFF, 16'hFFFF, 28'd178956970);
		random_moves(180);

		// Unbalanced and out-of-range settings, including a wrapping frequency
		load_profile(16'd100, 16'hFFFF, 16'd2000, 28'hFFFFFFF);
		random_moves(160);

		repeat (5) begin
			load_profile(16'($urandom_range(1, 5000)), 16'($urandom_range(1, 5000)),
				16'($urandom_range(50, 8000)), 28'($urandom_range(1000, 20000000)));
			random_moves(170);
		end

		wait (cmd_q.size() == 0 && timer_exp_q.size() == 0);
		repeat (300) @(posedge clk);
		if (mismatches == 0 && timer_exp_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
`default_nettype wire

// ===== files.f =====
design/stpr_pkg.sv
design/stpr_if.sv
design/stpr_div.sv
design/stepper_trapezoid_ramp.sv
tb/stepper_trapezoid_ramp_test.sv
